/* sv/pffa_pkg.sv */
`timescale 1ns / 1ps
// pffa_pkg: shared types, codes and widths of the page frame allocator
package pffa_pkg;

	localparam int CMD_W    = 3;
	localparam int IDX_W    = 15;
	localparam int STAT_W   = 3;
	localparam int REF_W    = 16;
	localparam int CFG_W    = 16;
	localparam int IN_W     = 24;
	localparam int OUT_W    = 40;
	localparam int OUT_PAD  = OUT_W - (IDX_W + STAT_W + REF_W + 1);
	localparam int IN_PAD   = IN_W - (CMD_W + IDX_W);
	localparam int PADDR_W  = 4;
	localparam int PDATA_W  = 32;

	localparam logic [CMD_W-1:0] CMD_INIT   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_ALLOC  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_FREE   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DECREF = 3'd3;
	localparam logic [CMD_W-1:0] CMD_INCREF = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
	localparam logic [STAT_W-1:0] ST_OOM       = 3'd1;
	localparam logic [STAT_W-1:0] ST_HEAD_BUSY = 3'd2;
	localparam logic [STAT_W-1:0] ST_FREE_BUSY = 3'd3;
	localparam logic [STAT_W-1:0] ST_LINKED    = 3'd4;
	localparam logic [STAT_W-1:0] ST_BAD       = 3'd5;

	localparam logic [1:0] REG_TOTAL    = 2'd0;
	localparam logic [1:0] REG_BASE     = 2'd1;
	localparam logic [1:0] REG_RESERVED = 2'd2;

	localparam logic [CFG_W-1:0] TOTAL_RST    = 16'd32768;
	localparam logic [CFG_W-1:0] BASE_RST     = 16'd160;
	localparam logic [CFG_W-1:0] RESERVED_RST = 16'd96;

	localparam int PAGE_HELD = 7;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_EXEC,
		S_INIT
	} state_t;

	typedef struct packed {
		logic clr_wr;
		logic take;
		logic rd;
		logic exec;
		logic init_start;
		logic init_wr;
	} ctl_t;

	typedef struct packed {
		logic clr_last;
		logic init_last;
		logic out_free;
		logic is_init;
	} sts_t;

endpackage

/* sv/page_frame_free_list_allocator.sv */
`timescale 1ns / 1ps
// page_frame_free_list_allocator: top level of the page frame allocator
//
//  channel | dir | handshake          | word
//  s_*     | in  | s_tvalid/s_tready  | command, page_index
//  m_*     | out | m_tvalid/m_tready  | result_page, status, ref_after, page_freed
//  apb     | in  | psel/penable/pready| total_pages, base_pages, reserved_after_base
//
//  alloc, free, decref, incref: a ram read in S_READ, then a write back in S_EXEC
//  through the page table ram; the next word can be taken in S_EXEC with the write back
//  init: the walk writes one page per cycle (pages 1 to effective total - 1)
//  after reset a clearing pass writes all MAX_PAGES entries, one per cycle; s_tready low
//  a result waits in the output register; the next word is taken, its write back waits
module page_frame_free_list_allocator #(
	parameter int MAX_PAGES  = 32768,
	parameter int COUNT_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// [2:0] command, [17:3] page_index, [23:18] zero
	input  logic [pffa_pkg::IN_W-1:0]    s_tdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// [14:0] result_page, [17:15] status, [33:18] ref_after, [34] page_freed, [39:35] zero
	output logic [pffa_pkg::OUT_W-1:0]   m_tdata,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [pffa_pkg::PADDR_W-1:0] paddr,
	input  logic [pffa_pkg::PDATA_W-1:0] pwdata,
	output logic [pffa_pkg::PDATA_W-1:0] prdata,
	output logic                         pready
);

	pffa_pkg::ctl_t             ctl;
	pffa_pkg::sts_t             sts;
	logic [pffa_pkg::CFG_W-1:0] total_pages;
	logic [pffa_pkg::CFG_W-1:0] base_pages;
	logic [pffa_pkg::CFG_W-1:0] reserved_after_base;
	logic [pffa_pkg::CMD_W-1:0] command;
	logic [pffa_pkg::IDX_W-1:0] page_index;

	assign command    = s_tdata[pffa_pkg::CMD_W-1:0];
	assign page_index = s_tdata[pffa_pkg::CMD_W+pffa_pkg::IDX_W-1:pffa_pkg::CMD_W];

	pffa_regs u_regs (
		.clk                (clk),
		.arst_n             (arst_n),
		.psel               (psel),
		.penable            (penable),
		.pwrite             (pwrite),
		.paddr              (paddr),
		.pwdata             (pwdata),
		.prdata             (prdata),
		.pready             (pready),
		.total_pages        (total_pages),
		.base_pages         (base_pages),
		.reserved_after_base(reserved_after_base)
	);

	pffa_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts     (sts),
		.ctl     (ctl)
	);

	pffa_dp #(
		.MAX_PAGES (MAX_PAGES),
		.COUNT_BITS(COUNT_BITS)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.ctl                (ctl),
		.sts                (sts),
		.command            (command),
		.page_index         (page_index),
		.total_pages        (total_pages),
		.base_pages         (base_pages),
		.reserved_after_base(reserved_after_base),
		.m_tvalid           (m_tvalid),
		.m_tready           (m_tready),
		.m_tdata            (m_tdata)
	);

endmodule

/* sv/pffa_ram.sv */
`timescale 1ns / 1ps
// pffa_ram: generic single-write, single-read ram with registered read data
module pffa_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 32768
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* sv/pffa_regs.sv */
`timescale 1ns / 1ps
// pffa_regs: apb configuration registers (total, base, reserved pages)
module pffa_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pffa_pkg::PADDR_W-1:0]  paddr,
	input  logic [pffa_pkg::PDATA_W-1:0]  pwdata,
	output logic [pffa_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	output logic [pffa_pkg::CFG_W-1:0]    total_pages,
	output logic [pffa_pkg::CFG_W-1:0]    base_pages,
	output logic [pffa_pkg::CFG_W-1:0]    reserved_after_base
);

	logic [pffa_pkg::CFG_W-1:0] total_q;
	logic [pffa_pkg::CFG_W-1:0] base_q;
	logic [pffa_pkg::CFG_W-1:0] rsv_q;
	logic [1:0]                 reg_idx;
	logic                       wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= pffa_pkg::TOTAL_RST;
			base_q  <= pffa_pkg::BASE_RST;
			rsv_q   <= pffa_pkg::RESERVED_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				pffa_pkg::REG_TOTAL:    total_q <= pwdata[pffa_pkg::CFG_W-1:0];
				pffa_pkg::REG_BASE:     base_q  <= pwdata[pffa_pkg::CFG_W-1:0];
				pffa_pkg::REG_RESERVED: rsv_q   <= pwdata[pffa_pkg::CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			pffa_pkg::REG_TOTAL:    prdata = pffa_pkg::PDATA_W'(total_q);
			pffa_pkg::REG_BASE:     prdata = pffa_pkg::PDATA_W'(base_q);
			pffa_pkg::REG_RESERVED: prdata = pffa_pkg::PDATA_W'(rsv_q);
			default:                prdata = '0;
		endcase
	end

	assign total_pages         = total_q;
	assign base_pages          = base_q;
	assign reserved_after_base = rsv_q;

endmodule

/* sv/pffa_ctrl.sv */
`timescale 1ns / 1ps
// pffa_ctrl: sequencing state machine for clear, init walk and read-modify-write
module pffa_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  pffa_pkg::sts_t sts,
	output pffa_pkg::ctl_t ctl
);

	pffa_pkg::state_t state_q;
	pffa_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pffa_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			pffa_pkg::S_CLEAR: begin
				ctl.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d = pffa_pkg::S_IDLE;
				end
			end
			pffa_pkg::S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					ctl.take = 1'b1;
					state_d  = pffa_pkg::S_READ;
				end
			end
			pffa_pkg::S_READ: begin
				if (sts.is_init) begin
					ctl.init_start = 1'b1;
					state_d        = pffa_pkg::S_INIT;
				end else begin
					ctl.rd  = 1'b1;
					state_d = pffa_pkg::S_EXEC;
				end
			end
			pffa_pkg::S_INIT: begin
				if (!sts.init_last) begin
					ctl.init_wr = 1'b1;
				end else if (sts.out_free) begin
					ctl.exec = 1'b1;
					state_d  = pffa_pkg::S_IDLE;
				end
			end
			pffa_pkg::S_EXEC: begin
				if (sts.out_free) begin
					ctl.exec = 1'b1;
					s_tready = 1'b1;
					if (s_tvalid) begin
						ctl.take = 1'b1;
						state_d  = pffa_pkg::S_READ;
					end else begin
						state_d = pffa_pkg::S_IDLE;
					end
				end
			end
			default: state_d = pffa_pkg::S_IDLE;
		endcase
	end

endmodule

/* sv/pffa_dp.sv */
`timescale 1ns / 1ps
// pffa_dp: page table ram, free-list head, walk cursor and result register
module pffa_dp #(
	parameter int MAX_PAGES  = 32768,
	parameter int COUNT_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  pffa_pkg::ctl_t               ctl,
	output pffa_pkg::sts_t               sts,
	input  logic [pffa_pkg::CMD_W-1:0]   command,
	input  logic [pffa_pkg::IDX_W-1:0]   page_index,
	input  logic [pffa_pkg::CFG_W-1:0]   total_pages,
	input  logic [pffa_pkg::CFG_W-1:0]   base_pages,
	input  logic [pffa_pkg::CFG_W-1:0]   reserved_after_base,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [pffa_pkg::OUT_W-1:0]   m_tdata
);

	localparam int AW = $clog2(MAX_PAGES);
	localparam int CW = COUNT_BITS;
	localparam int TW = (AW + 1 > pffa_pkg::CFG_W + 1) ? AW + 1 : pffa_pkg::CFG_W + 1;
	localparam int MW = AW + CW;
	localparam logic [CW-1:0] CNT_MAX  = {CW{1'b1}};
	localparam logic [TW-1:0] PAGES_TW = TW'(MAX_PAGES);
	localparam logic [TW-1:0] LAST_TW  = TW'(MAX_PAGES - 1);

	logic [pffa_pkg::CMD_W-1:0]  cmd_q;
	logic [pffa_pkg::IDX_W-1:0]  idx_q;
	logic [AW-1:0]               head_q;
	logic [TW-1:0]               cursor_q;
	logic                        ovalid_q;
	logic [pffa_pkg::OUT_W-1:0]  odata_q;

	logic [TW-1:0]               total_tw;
	logic [TW-1:0]               eff_total;
	logic [TW-1:0]               lo_tw;
	logic [TW-1:0]               hi_tw;
	logic [TW-1:0]               idx_tw;
	logic                        idx_ok;
	logic                        held;
	logic [AW-1:0]               idx_a;
	logic [AW-1:0]               rd_addr;

	logic                        we;
	logic [AW-1:0]               waddr;
	logic [MW-1:0]               wdata;
	logic [MW-1:0]               rdata;
	logic [CW-1:0]               cnt;
	logic [AW-1:0]               link;
	logic [CW-1:0]               cnt_dn;
	logic [CW-1:0]               cnt_up;

	logic                        ex_we;
	logic [MW-1:0]               ex_wdata;
	logic [AW-1:0]               head_d;
	logic [pffa_pkg::IDX_W-1:0]  o_page;
	logic [pffa_pkg::STAT_W-1:0] o_st;
	logic [pffa_pkg::REF_W-1:0]  o_ref;
	logic                        o_freed;

	assign total_tw  = TW'(total_pages);
	assign eff_total = (total_tw > PAGES_TW) ? PAGES_TW : total_tw;
	assign lo_tw     = TW'(base_pages);
	assign hi_tw     = TW'(base_pages) + TW'(reserved_after_base);
	assign idx_tw    = TW'(idx_q);
	assign idx_ok    = (idx_q != '0) && (idx_tw < eff_total);
	assign idx_a     = AW'(idx_q);
	assign rd_addr   = (cmd_q == pffa_pkg::CMD_ALLOC) ? head_q : idx_a;
	assign held      = (cursor_q == TW'(pffa_pkg::PAGE_HELD)) ||
		((cursor_q >= lo_tw) && (cursor_q < hi_tw));

	assign cnt    = rdata[CW-1:0];
	assign link   = rdata[MW-1:CW];
	assign cnt_dn = cnt - CW'(1);
	assign cnt_up = cnt + CW'(1);

	// one read-modify-write decision per command
	always_comb begin
		ex_we    = 1'b0;
		ex_wdata = '0;
		head_d   = head_q;
		o_page   = idx_q;
		o_st     = pffa_pkg::ST_BAD;
		o_ref    = '0;
		o_freed  = 1'b0;
		unique case (cmd_q)
			pffa_pkg::CMD_INIT: begin
				o_st = pffa_pkg::ST_OK;
			end
			pffa_pkg::CMD_ALLOC: begin
				if (head_q == '0) begin
					o_page = '0;
					o_st   = pffa_pkg::ST_OOM;
				end else if (cnt != '0) begin
					o_page = pffa_pkg::IDX_W'(head_q);
					o_st   = pffa_pkg::ST_HEAD_BUSY;
					o_ref  = pffa_pkg::REF_W'(cnt);
				end else begin
					o_page   = pffa_pkg::IDX_W'(head_q);
					o_st     = pffa_pkg::ST_OK;
					head_d   = link;
					ex_we    = 1'b1;
					ex_wdata = {{AW{1'b0}}, cnt};
				end
			end
			pffa_pkg::CMD_FREE: begin
				if (!idx_ok) begin
					o_st = pffa_pkg::ST_BAD;
				end else if (cnt != '0) begin
					o_st  = pffa_pkg::ST_FREE_BUSY;
					o_ref = pffa_pkg::REF_W'(cnt);
				end else if (link != '0) begin
					o_st = pffa_pkg::ST_LINKED;
				end else begin
					o_st     = pffa_pkg::ST_OK;
					o_freed  = 1'b1;
					ex_we    = 1'b1;
					ex_wdata = {head_q, {CW{1'b0}}};
					head_d   = idx_a;
				end
			end
			pffa_pkg::CMD_DECREF: begin
				if (!idx_ok || cnt == '0) begin
					o_st = pffa_pkg::ST_BAD;
				end else if (cnt_dn != '0) begin
					o_st     = pffa_pkg::ST_OK;
					o_ref    = pffa_pkg::REF_W'(cnt_dn);
					ex_we    = 1'b1;
					ex_wdata = {link, cnt_dn};
				end else if (link != '0) begin
					o_st     = pffa_pkg::ST_LINKED;
					ex_we    = 1'b1;
					ex_wdata = {link, {CW{1'b0}}};
				end else begin
					o_st     = pffa_pkg::ST_OK;
					o_freed  = 1'b1;
					ex_we    = 1'b1;
					ex_wdata = {head_q, {CW{1'b0}}};
					head_d   = idx_a;
				end
			end
			pffa_pkg::CMD_INCREF: begin
				if (!idx_ok) begin
					o_st = pffa_pkg::ST_BAD;
				end else if (cnt == CNT_MAX) begin
					o_st  = pffa_pkg::ST_BAD;
					o_ref = pffa_pkg::REF_W'(cnt);
				end else begin
					o_st     = pffa_pkg::ST_OK;
					o_ref    = pffa_pkg::REF_W'(cnt_up);
					ex_we    = 1'b1;
					ex_wdata = {link, cnt_up};
				end
			end
			default: begin
				o_st = pffa_pkg::ST_BAD;
			end
		endcase
	end

	// ram write port: clearing sweep, init walk or command update
	always_comb begin
		we    = ctl.clr_wr | ctl.init_wr | (ctl.exec & ex_we);
		waddr = (ctl.clr_wr | ctl.init_wr) ? cursor_q[AW-1:0] : rd_addr;
		priority if (ctl.clr_wr) begin
			wdata = '0;
		end else if (ctl.init_wr) begin
			wdata = held ? {{AW{1'b0}}, CW'(1)} : {head_q, {CW{1'b0}}};
		end else begin
			wdata = ex_wdata;
		end
	end

	pffa_ram #(
		.WIDTH(MW),
		.DEPTH(MAX_PAGES)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (ctl.rd),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	always_ff @(posedge clk) begin
		if (ctl.take) begin
			cmd_q <= command;
			idx_q <= page_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			cursor_q <= '0;
		end else begin
			if (ctl.clr_wr) begin
				cursor_q <= cursor_q + TW'(1);
			end
			if (ctl.init_start) begin
				cursor_q <= TW'(1);
				head_q   <= '0;
			end
			if (ctl.init_wr) begin
				cursor_q <= cursor_q + TW'(1);
				if (!held) begin
					head_q <= cursor_q[AW-1:0];
				end
			end
			if (ctl.exec) begin
				head_q <= head_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (ctl.exec) begin
			ovalid_q <= 1'b1;
		end else if (m_tready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			odata_q <= {{pffa_pkg::OUT_PAD{1'b0}}, o_freed, o_ref, o_st, o_page};
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = odata_q;

	assign sts.clr_last  = (cursor_q == LAST_TW);
	assign sts.init_last = (cursor_q >= eff_total);
	assign sts.out_free  = !ovalid_q || m_tready;
	assign sts.is_init   = (cmd_q == pffa_pkg::CMD_INIT);

endmodule

/* sv/pffa_checker.sv */
`timescale 1ns / 1ps
// pffa_checker: port-level assertions for the page frame allocator, bound to the top
module pffa_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_tvalid,
	input logic                       s_tready,
	input logic [pffa_pkg::IN_W-1:0]  s_tdata,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [pffa_pkg::OUT_W-1:0] m_tdata
);

	logic [pffa_pkg::STAT_W-1:0] out_st;
	logic                        out_freed;

	assign out_st    = m_tdata[17:15];
	assign out_freed = m_tdata[34];

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// one word at a time: a read cycle always follows acceptance
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken in the cycle after acceptance");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> out_st <= pffa_pkg::ST_BAD)
		else $error("status code out of range");

	// a push leaves the count at zero with ok status
	a_freed_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && out_freed |-> out_st == pffa_pkg::ST_OK && m_tdata[33:18] == '0)
		else $error("freed page with nonzero count or bad status");

	a_oom_page: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && out_st == pffa_pkg::ST_OOM |-> m_tdata[14:0] == '0 && !out_freed)
		else $error("out of memory result names a page");

endmodule

bind page_frame_free_list_allocator pffa_checker u_pffa_checker (.*);

/* dv/tb_page_frame_free_list_allocator.sv */
`timescale 1ns / 1ps
// tb_page_frame_free_list_allocator: self-checking testbench of the page frame allocator
module tb_page_frame_free_list_allocator;

	localparam int PAGE_SLOTS   = 32768;
	localparam int CYCLE_LIMIT  = 2000000;
	localparam int OUTPUT_HOLD  = 300;
	localparam int REPORT_LIMIT = 10;
	localparam logic [pffa_pkg::CMD_W-1:0] CMD_SPARE_LO = 3'd5;
	localparam logic [pffa_pkg::CMD_W-1:0] CMD_SPARE_HI = 3'd7;
	localparam logic [pffa_pkg::IDX_W-1:0] HELD_IDX = pffa_pkg::IDX_W'(pffa_pkg::PAGE_HELD);

	typedef struct packed {
		logic [pffa_pkg::IDX_W-1:0]  page;
		logic [pffa_pkg::STAT_W-1:0] status;
		logic [pffa_pkg::REF_W-1:0]  count_after;
		logic                        freed;
	} result_word_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [pffa_pkg::IN_W-1:0]     s_tdata = '0;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [pffa_pkg::OUT_W-1:0]    m_tdata;
	logic                          psel = 1'b0;
	logic                          penable = 1'b0;
	logic                          pwrite = 1'b0;
	logic [pffa_pkg::PADDR_W-1:0]  paddr = '0;
	logic [pffa_pkg::PDATA_W-1:0]  pwdata = '0;
	logic [pffa_pkg::PDATA_W-1:0]  prdata;
	logic                          pready;

	// allocator state as the block should hold it
	logic [pffa_pkg::REF_W-1:0]    page_refs [PAGE_SLOTS];
	logic [pffa_pkg::IDX_W-1:0]    page_next [PAGE_SLOTS];
	logic [pffa_pkg::IDX_W-1:0]    head_page = '0;
	logic [pffa_pkg::CFG_W-1:0]    cfg_total = pffa_pkg::TOTAL_RST;
	logic [pffa_pkg::CFG_W-1:0]    cfg_base = pffa_pkg::BASE_RST;
	logic [pffa_pkg::CFG_W-1:0]    cfg_reserved = pffa_pkg::RESERVED_RST;

	result_word_t        results_due[$];
	result_word_t        last_result;
	result_word_t        seen_want;
	int unsigned         mismatches = 0;
	bit                  idle_on = 1'b1;
	bit                  hold_req = 1'b0;
	int unsigned         hold_left = 0;

	page_frame_free_list_allocator dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic void flag_error(string msg);
		mismatches++;
		if (mismatches <= REPORT_LIMIT) begin
			$display("mismatch: %s", msg);
		end
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			flag_error($sformatf("%s expected %0h got %0h", name, want, got));
		end
	endfunction

	function automatic int unsigned pages_present();
		return (cfg_total > PAGE_SLOTS) ? PAGE_SLOTS : 32'(cfg_total);
	endfunction

	function automatic void push_free(logic [pffa_pkg::IDX_W-1:0] pg);
		page_next[pg] = head_page;
		head_page = pg;
	endfunction

	function automatic void push_if_unlinked(logic [pffa_pkg::IDX_W-1:0] pg,
			inout result_word_t r);
		if (page_next[pg] != '0) begin
			r.status = pffa_pkg::ST_LINKED;
		end else begin
			push_free(pg);
			r.freed = 1'b1;
		end
	endfunction

	function automatic result_word_t allocator_apply(logic [pffa_pkg::CMD_W-1:0] cmd,
			logic [pffa_pkg::IDX_W-1:0] idx);
		result_word_t r;
		int unsigned limit;
		int unsigned lo;
		int unsigned hi;
		int unsigned p;
		logic [pffa_pkg::IDX_W-1:0] h;
		limit = pages_present();
		r = '{page: idx, status: pffa_pkg::ST_OK, count_after: '0, freed: 1'b0};
		case (cmd)
			pffa_pkg::CMD_INIT: begin
				lo = int'(cfg_base);
				hi = int'(cfg_base) + int'(cfg_reserved);
				head_page = '0;
				for (p = 1; p < limit; p++) begin
					if (p == pffa_pkg::PAGE_HELD || (p >= lo && p < hi)) begin
						page_refs[p] = pffa_pkg::REF_W'(1);
						page_next[p] = '0;
					end else begin
						page_refs[p] = '0;
						push_free(pffa_pkg::IDX_W'(p));
					end
				end
			end
			pffa_pkg::CMD_ALLOC: begin
				h = head_page;
				r.page = h;
				if (h == '0) begin
					r.status = pffa_pkg::ST_OOM;
				end else if (page_refs[h] != '0) begin
					r.status = pffa_pkg::ST_HEAD_BUSY;
					r.count_after = page_refs[h];
				end else begin
					head_page = page_next[h];
					page_next[h] = '0;
				end
			end
			default: begin
				if (cmd > pffa_pkg::CMD_INCREF || idx == '0 || idx >= limit) begin
					r.status = pffa_pkg::ST_BAD;
				end else if (cmd == pffa_pkg::CMD_FREE) begin
					if (page_refs[idx] != '0) begin
						r.status = pffa_pkg::ST_FREE_BUSY;
						r.count_after = page_refs[idx];
					end else begin
						push_if_unlinked(idx, r);
					end
				end else if (cmd == pffa_pkg::CMD_DECREF) begin
					if (page_refs[idx] == '0) begin
						r.status = pffa_pkg::ST_BAD;
					end else begin
						page_refs[idx] = page_refs[idx] - 1'b1;
						if (page_refs[idx] != '0) begin
							r.count_after = page_refs[idx];
						end else begin
							push_if_unlinked(idx, r);
						end
					end
				end else begin
					if (page_refs[idx] == '1) begin
						r.status = pffa_pkg::ST_BAD;
						r.count_after = page_refs[idx];
					end else begin
						page_refs[idx] = page_refs[idx] + 1'b1;
						r.count_after = page_refs[idx];
					end
				end
			end
		endcase
		return r;
	endfunction

	task automatic send_word(logic [pffa_pkg::CMD_W-1:0] cmd, logic [pffa_pkg::IDX_W-1:0] idx);
		if (idle_on) begin
			while ($urandom_range(0, 99) < 22) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{pffa_pkg::IN_PAD{1'b0}}, idx, cmd};
		do @(posedge clk); while (!s_tready);
		last_result = allocator_apply(cmd, idx);
		results_due.push_back(last_result);
	endtask

	task automatic wait_results_done();
		s_tvalid <= 1'b0;
		while (results_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] reg_id, logic [pffa_pkg::CFG_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_id, 2'b00};
		pwdata <= {{(pffa_pkg::PDATA_W - pffa_pkg::CFG_W){1'b0}}, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		check_field("register readback", 32'(value), 32'(prdata[pffa_pkg::CFG_W-1:0]));
		psel <= 1'b0;
		penable <= 1'b0;
		case (reg_id)
			pffa_pkg::REG_TOTAL: cfg_total = value;
			pffa_pkg::REG_BASE: cfg_base = value;
			default: cfg_reserved = value;
		endcase
		@(posedge clk);
	endtask

	task automatic set_layout(logic [pffa_pkg::CFG_W-1:0] total,
			logic [pffa_pkg::CFG_W-1:0] base, logic [pffa_pkg::CFG_W-1:0] reserved);
		wait_results_done();
		write_reg(pffa_pkg::REG_TOTAL, total);
		write_reg(pffa_pkg::REG_BASE, base);
		write_reg(pffa_pkg::REG_RESERVED, reserved);
	endtask

	// freshly cleared tables, no init yet
	task automatic test_before_init();
		send_word(pffa_pkg::CMD_ALLOC, '0);
		send_word(pffa_pkg::CMD_FREE, 15'd3);
		send_word(pffa_pkg::CMD_ALLOC, 15'h7FFF);
		send_word(pffa_pkg::CMD_FREE, '0);
		send_word(CMD_SPARE_LO, 15'h7FFF);
		send_word(CMD_SPARE_HI, 15'h2AAA);
	endtask

	// init with the register reset values, then every operation and error cases of each
	task automatic test_default_layout();
		send_word(pffa_pkg::CMD_INIT, 15'h7FFF);
		send_word(pffa_pkg::CMD_INCREF, 15'd32767);
		send_word(pffa_pkg::CMD_ALLOC, '0);
		send_word(pffa_pkg::CMD_DECREF, 15'd32767);
		send_word(pffa_pkg::CMD_ALLOC, '0);
		send_word(pffa_pkg::CMD_DECREF, 15'd7);
		send_word(pffa_pkg::CMD_ALLOC, '0);
		send_word(pffa_pkg::CMD_FREE, 15'd200);
		send_word(pffa_pkg::CMD_FREE, 15'd32766);
		send_word(pffa_pkg::CMD_DECREF, 15'd32766);
		send_word(pffa_pkg::CMD_FREE, 15'd32767);
		send_word(pffa_pkg::CMD_INCREF, '0);
	endtask

	task automatic test_register_extremes();
		set_layout(16'd0, 16'd0, 16'd0);
		send_word(pffa_pkg::CMD_INIT, '0);
		send_word(pffa_pkg::CMD_ALLOC, '0);
		send_word(pffa_pkg::CMD_FREE, 15'd1);
		set_layout(16'hFFFF, 16'd0, 16'hFFFF);
		send_word(pffa_pkg::CMD_INIT, 15'd5);
		send_word(pffa_pkg::CMD_ALLOC, '0);
		send_word(pffa_pkg::CMD_INCREF, 15'd20);
		send_word(pffa_pkg::CMD_DECREF, 15'd20);
		send_word(pffa_pkg::CMD_DECREF, 15'd20);
		send_word(pffa_pkg::CMD_ALLOC, '0);
		set_layout(16'd40, 16'hFFFF, 16'hFFFF);
		send_word(pffa_pkg::CMD_INIT, '0);
		send_word(pffa_pkg::CMD_ALLOC, '0);
	endtask

	// walk one count up, back down past zero, no idling on either side
	task automatic test_count_walk();
		int unsigned n;
		set_layout(16'd16, 16'd10, 16'd2);
		idle_on = 1'b0;
		send_word(pffa_pkg::CMD_INIT, '0);
		for (n = 0; n < 20; n++) begin
			send_word(pffa_pkg::CMD_INCREF, HELD_IDX);
		end
		while (page_refs[pffa_pkg::PAGE_HELD] != '0) begin
			send_word(pffa_pkg::CMD_DECREF, HELD_IDX);
		end
		send_word(pffa_pkg::CMD_DECREF, HELD_IDX);
		send_word(pffa_pkg::CMD_INCREF, HELD_IDX);
		wait_results_done();
		idle_on = 1'b1;
	endtask

	task automatic test_output_stall();
		int unsigned n;
		logic [pffa_pkg::IDX_W-1:0] idx;
		set_layout(16'd48, 16'd20, 16'd6);
		send_word(pffa_pkg::CMD_INIT, '0);
		wait_results_done();
		@(negedge clk);
		hold_req = 1'b1;
		@(posedge clk);
		for (n = 0; n < 24; n++) begin
			idx = pffa_pkg::IDX_W'($urandom_range(1, 47));
			case (n % 4)
				0: send_word(pffa_pkg::CMD_INCREF, idx);
				1: send_word(pffa_pkg::CMD_FREE, idx);
				2: send_word(pffa_pkg::CMD_DECREF, idx);
				default: send_word(pffa_pkg::CMD_ALLOC, idx);
			endcase
		end
		wait_results_done();
		for (n = 0; n < 6; n++) begin
			send_word(pffa_pkg::CMD_ALLOC, '0);
		end
	endtask

	task automatic test_random_traffic();
		int unsigned phase;
		int unsigned n;
		int unsigned pick;
		int unsigned limit;
		int unsigned total;
		logic [pffa_pkg::CMD_W-1:0] cmd;
		logic [pffa_pkg::IDX_W-1:0] idx;
		logic [pffa_pkg::IDX_W-1:0] owned[$];
		for (phase = 0; phase < 10; phase++) begin
			total = (phase == 3) ? $urandom_range(600, 1500) : $urandom_range(2, 96);
			set_layout(pffa_pkg::CFG_W'(total), pffa_pkg::CFG_W'($urandom_range(0, total + 8)),
				(phase == 6) ? 16'hFFFF : 16'($urandom_range(0, 24)));
			idle_on = (phase != 5);
			limit = pages_present();
			owned.delete();
			send_word(pffa_pkg::CMD_INIT, pffa_pkg::IDX_W'($urandom_range(0, 32767)));
			for (n = 0; n < 40; n++) begin
				pick = $urandom_range(0, 99);
				if (owned.size() != 0 && $urandom_range(0, 9) < 7) begin
					idx = owned[$urandom_range(0, owned.size() - 1)];
				end else begin
					idx = pffa_pkg::IDX_W'((limit >= 2) ? $urandom_range(1, limit - 1) :
						$urandom_range(0, 32767));
				end
				if (pick < 30) begin
					cmd = pffa_pkg::CMD_ALLOC;
					idx = pffa_pkg::IDX_W'($urandom_range(0, 32767));
				end else if (pick < 45) begin
					cmd = pffa_pkg::CMD_FREE;
				end else if (pick < 62) begin
					cmd = pffa_pkg::CMD_DECREF;
				end else if (pick < 80) begin
					cmd = pffa_pkg::CMD_INCREF;
				end else if (pick < 88) begin
					cmd = pffa_pkg::CMD_W'($urandom_range(pffa_pkg::CMD_FREE,
						pffa_pkg::CMD_INCREF));
					idx = ($urandom_range(0, 1) == 0 || limit >= PAGE_SLOTS) ? '0 :
						pffa_pkg::IDX_W'($urandom_range(limit, 32767));
				end else if (pick < 93) begin
					cmd = pffa_pkg::CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
					idx = pffa_pkg::IDX_W'($urandom_range(0, 32767));
				end else if (pick < 96) begin
					cmd = pffa_pkg::CMD_INIT;
					idx = pffa_pkg::IDX_W'($urandom_range(0, 32767));
				end else begin
					cmd = pffa_pkg::CMD_W'($urandom_range(0, 7));
					idx = pffa_pkg::IDX_W'($urandom_range(0, 32767));
				end
				send_word(cmd, idx);
				if (cmd == pffa_pkg::CMD_INIT) begin
					owned.delete();
				end else if (cmd == pffa_pkg::CMD_ALLOC && last_result.status == pffa_pkg::ST_OK) begin
					owned.push_back(last_result.page);
					if (owned.size() > 16) begin
						void'(owned.pop_front());
					end
				end
			end
		end
		idle_on = 1'b1;
	endtask

	// receiver: random idling plus a long hold when asked
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = OUTPUT_HOLD;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (idle_on) begin
			m_tready <= ($urandom_range(0, 99) >= 22);
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (results_due.size() == 0) begin
				flag_error($sformatf("unexpected word %h", m_tdata));
			end else begin
				seen_want = results_due.pop_front();
				check_field("result_page", 32'(seen_want.page), 32'(m_tdata[14:0]));
				check_field("status", 32'(seen_want.status), 32'(m_tdata[17:15]));
				check_field("ref_after", 32'(seen_want.count_after), 32'(m_tdata[33:18]));
				check_field("page_freed", 32'(seen_want.freed), 32'(m_tdata[34]));
			end
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		for (int p = 0; p < PAGE_SLOTS; p++) begin
			page_refs[p] = '0;
			page_next[p] = '0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_before_init();
		test_default_layout();
		test_register_extremes();
		test_count_walk();
		test_output_stall();
		test_random_traffic();
		wait_results_done();
		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
